// ----- hdl/skseq_pkg.sv -----
// skseq_pkg: shared types and constants of the sprite keyframe sequencer
`timescale 1ns / 1ps
`default_nettype none
package skseq_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;

  // opcodes of an input transaction
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_PLAY     = 3'd1,
    OP_PLAY_REV = 3'd2,
    OP_STOP     = 3'd3,
    OP_LOAD     = 3'd4
  } opcode_t;

  // wrap behavior for a position outside the clip
  typedef enum logic [1:0] {
    WRAP_ONCE     = 2'd0,
    WRAP_LOOP     = 2'd1,
    WRAP_PINGPONG = 2'd2,
    WRAP_CLAMP    = 2'd3
  } wrap_sel_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_SEL    = 2'd0,
    CFG_CLAMP_FRAME = 2'd1,
    CFG_FRAME_COUNT = 2'd2
  } cfg_index_t;

  // one keyframe table entry
  typedef struct packed {
    logic [23:0] duration;
    logic [7:0]  sprite;
    logic [7:0]  image;
  } key_entry_t;

  // one result transaction
  typedef struct packed {
    logic              frame_shown;
    logic [7:0]        out_sprite;
    logic [7:0]        out_image;
    logic              stopped_event;
    logic              is_playing;
    logic signed [7:0] position;
  } result_t;

  // playback status seen by the top level
  typedef struct packed {
    logic              playing;
    logic              reversed;
    logic signed [7:0] position;
  } play_status_t;

endpackage
`default_nettype wire

// ----- hdl/skseq_if.sv -----
// skseq_if: input and output channel interfaces of the sequencer
`timescale 1ns / 1ps
`default_nettype none
interface skseq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] delta_time;
  logic [5:0]  key_slot;
  logic [23:0] key_duration;
  logic [7:0]  key_sprite;
  logic [7:0]  key_image;

  modport source (output valid, opcode, delta_time, key_slot, key_duration,
                  key_sprite, key_image, input ready);
  modport sink (input valid, opcode, delta_time, key_slot, key_duration,
                key_sprite, key_image, output ready);
endinterface

interface skseq_out_if;
  logic              valid;
  logic              ready;
  logic              frame_shown;
  logic [7:0]        out_sprite;
  logic [7:0]        out_image;
  logic              stopped_event;
  logic              is_playing;
  logic signed [7:0] position;

  modport source (output valid, frame_shown, out_sprite, out_image, stopped_event,
                  is_playing, position, input ready);
  modport sink (input valid, frame_shown, out_sprite, out_image, stopped_event,
                is_playing, position, output ready);
endinterface
`default_nettype wire

// ----- hdl/skseq_table.sv -----
// skseq_table: keyframe memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module skseq_table #(
  parameter int DEPTH = skseq_pkg::MAX_FRAMES_DEF,
  parameter int AW    = 6
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire skseq_pkg::key_entry_t  wdata,
  input  wire logic [AW-1:0]          raddr,
  output skseq_pkg::key_entry_t       rdata
);

  skseq_pkg::key_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: a load to the entry being read is seen at once
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/skseq_step.sv -----
// skseq_step: playback state, configuration registers and step logic
`timescale 1ns / 1ps
`default_nettype none
module skseq_step #(
  parameter int MAX_FRAMES = skseq_pkg::MAX_FRAMES_DEF,
  parameter int AW         = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [skseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [skseq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              acc,
  input  wire logic [2:0]                        opcode,
  input  wire logic [15:0]                       delta_time,
  input  wire logic [5:0]                        key_slot,
  input  wire logic [23:0]                       key_duration,
  input  wire logic [7:0]                        key_sprite,
  input  wire logic [7:0]                        key_image,
  input  wire skseq_pkg::key_entry_t             rd_entry,
  output logic [AW-1:0]                          rd_addr,
  output logic                                   wr_en,
  output logic [AW-1:0]                          wr_addr,
  output skseq_pkg::key_entry_t                  wr_entry,
  output skseq_pkg::result_t                     result,
  output skseq_pkg::play_status_t                status
);

  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAMES);

  logic [1:0]        wrap_sel;
  logic [5:0]        clamp_frame;
  logic [6:0]        frame_count;
  logic signed [7:0] pos, pos_next;
  logic [31:0]       elapsed, elapsed_next;
  logic              playing, playing_next;
  logic              reversed, reversed_next;

  logic [8:0]  len_wide;
  logic [7:0]  len;
  logic        in_range;
  logic        early;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic        shown, stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_sel    <= '0;
      clamp_frame <= '0;
      frame_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        skseq_pkg::CFG_WRAP_SEL:    wrap_sel    <= cfg_wdata[1:0];
        skseq_pkg::CFG_CLAMP_FRAME: clamp_frame <= cfg_wdata[5:0];
        skseq_pkg::CFG_FRAME_COUNT: frame_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign len_wide = ({2'b00, frame_count} > MAX_LEN) ? MAX_LEN : {2'b00, frame_count};
  assign len      = len_wide[7:0];
  assign in_range = !pos[7] && (pos < len);
  assign early    = elapsed < {8'h00, rd_entry.duration};
  assign sum      = {1'b0, elapsed} + {17'h0, delta_time};
  assign sum_sat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_comb begin
    pos_next      = pos;
    elapsed_next  = elapsed;
    playing_next  = playing;
    reversed_next = reversed;
    shown         = 1'b0;
    stopped       = 1'b0;
    if (acc) begin
      case (opcode)
        skseq_pkg::OP_TICK: begin
          if (playing) begin
            if (in_range) begin
              if (early) begin
                elapsed_next = sum_sat;
              end else begin
                shown        = 1'b1;
                elapsed_next = elapsed - {8'h00, rd_entry.duration};
                pos_next     = reversed ? pos - 8'sd1 : pos + 8'sd1;
              end
            end else begin
              case (wrap_sel)
                skseq_pkg::WRAP_ONCE: begin
                  playing_next = 1'b0;
                  pos_next     = '0;
                  stopped      = 1'b1;
                end
                skseq_pkg::WRAP_LOOP: pos_next = '0;
                skseq_pkg::WRAP_PINGPONG: begin
                  if (!reversed && (pos == len)) begin
                    reversed_next = 1'b1;
                    pos_next      = pos - 8'sd1;
                  end else if (reversed && pos[7]) begin
                    reversed_next = 1'b0;
                    playing_next  = 1'b0;
                    pos_next      = '0;
                    elapsed_next  = '0;
                    stopped       = 1'b1;
                  end
                end
                default: pos_next = {2'b00, clamp_frame};
              endcase
            end
          end
        end
        skseq_pkg::OP_PLAY: begin
          pos_next      = '0;
          elapsed_next  = '0;
          playing_next  = 1'b1;
          reversed_next = 1'b0;
        end
        skseq_pkg::OP_PLAY_REV: begin
          pos_next      = len - 8'd1;
          elapsed_next  = '0;
          playing_next  = 1'b1;
          reversed_next = 1'b1;
        end
        skseq_pkg::OP_STOP: begin
          playing_next = 1'b0;
          pos_next     = '0;
          stopped      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      elapsed  <= '0;
      playing  <= 1'b0;
      reversed <= 1'b0;
    end else begin
      pos      <= pos_next;
      elapsed  <= elapsed_next;
      playing  <= playing_next;
      reversed <= reversed_next;
    end
  end

  // next position addresses the table so its entry is ready for the next item
  assign rd_addr = rst ? '0 : pos_next[AW-1:0];

  assign wr_en             = acc && (opcode == skseq_pkg::OP_LOAD) &&
                             ({3'b000, key_slot} < MAX_LEN);
  assign wr_addr           = AW'(key_slot);
  assign wr_entry.duration = key_duration;
  assign wr_entry.sprite   = key_sprite;
  assign wr_entry.image    = key_image;

  assign result.frame_shown   = shown;
  assign result.out_sprite    = shown ? rd_entry.sprite : 8'h00;
  assign result.out_image     = shown ? rd_entry.image : 8'h00;
  assign result.stopped_event = stopped;
  assign result.is_playing    = playing_next;
  assign result.position      = pos_next;

  assign status.playing  = playing;
  assign status.reversed = reversed;
  assign status.position = pos;

endmodule
`default_nettype wire

// ----- hdl/skseq_outq.sv -----
// skseq_outq: two-entry result queue between the step logic and the output
`timescale 1ns / 1ps
`default_nettype none
module skseq_outq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire skseq_pkg::result_t  push_data,
  output logic                     can_push,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output skseq_pkg::result_t       out_data
);

  skseq_pkg::result_t slots [2];
  logic       head, tail;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign can_push  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sprite_keyframe_sequencer.sv -----
// sprite_keyframe_sequencer: top level of the keyframe animation sequencer
//
//  channel   dir  handshake            contents
//  in_ch     in   valid / ready        opcode, delta_time, key_* load fields
//  out_ch    out  valid / ready        frame_shown, sprite, image, stop, status
//  cfg_*     in   cfg_we, no stall     wrap_sel, clamp_frame, frame_count
//
// one transaction per cycle while the result queue has room; each result is queued at acceptance
// the keyframe memory is read at the next position, so its entry is on hand
//   for the following tick with no bubble; a load to that entry is forwarded
// synchronous active-high reset; no clearing pass, the tables are loaded
//   by the user before play
// a two-entry result queue keeps in_ch.ready high while one result waits
`timescale 1ns / 1ps
`default_nettype none
module sprite_keyframe_sequencer #(
  parameter int MAX_FRAMES = skseq_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [skseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [skseq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  skseq_in_if.sink                               in_ch,
  skseq_out_if.source                            out_ch
);

  // table address width, at least one bit
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic                    acc;
  logic                    can_push;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  skseq_pkg::key_entry_t   wr_entry;
  skseq_pkg::key_entry_t   rd_entry;
  skseq_pkg::result_t      result;
  skseq_pkg::result_t      out_data;
  skseq_pkg::play_status_t status;
  logic                    out_valid;

  // input transaction accepted whenever the result queue has room
  assign in_ch.ready = can_push;
  assign acc         = in_ch.valid && can_push;

  skseq_table #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  skseq_step #(
    .MAX_FRAMES (MAX_FRAMES),
    .AW         (AW)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .acc          (acc),
    .opcode       (in_ch.opcode),
    .delta_time   (in_ch.delta_time),
    .key_slot     (in_ch.key_slot),
    .key_duration (in_ch.key_duration),
    .key_sprite   (in_ch.key_sprite),
    .key_image    (in_ch.key_image),
    .rd_entry     (rd_entry),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_entry     (wr_entry),
    .result       (result),
    .status       (status)
  );

  skseq_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.frame_shown   = out_data.frame_shown;
  assign out_ch.out_sprite    = out_data.out_sprite;
  assign out_ch.out_image     = out_data.out_image;
  assign out_ch.stopped_event = out_data.stopped_event;
  assign out_ch.is_playing    = out_data.is_playing;
  assign out_ch.position      = out_data.position;

`ifndef SYNTHESIS
  // a full queue always has a result on offer
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !can_push |-> out_valid)
    else $error("result queue full with no output valid");

  // a frame is never issued in the same step that playback stops
  a_shown_not_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.frame_shown && out_data.stopped_event))
    else $error("frame issued together with stop event");

  // a stop transaction leaves playback halted at position zero
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (acc && (in_ch.opcode == skseq_pkg::OP_STOP)) |=>
      (!status.playing && (status.position == 8'sd0)))
    else $error("stop did not halt playback");

  // forward play starts at position zero, not reversed
  a_play_starts: assert property (@(posedge clk) disable iff (rst)
    (acc && (in_ch.opcode == skseq_pkg::OP_PLAY)) |=>
      (status.playing && !status.reversed && (status.position == 8'sd0)))
    else $error("play did not start at position zero");
`endif

endmodule
`default_nettype wire

// ----- tb/sprite_keyframe_sequencer_tb.sv -----
// sprite_keyframe_sequencer_tb: self-checking testbench for the keyframe animation sequencer
`timescale 1ns / 1ps
module sprite_keyframe_sequencer_tb;

  localparam int MAX_FRAMES = skseq_pkg::MAX_FRAMES_DEF;
  localparam int CFG_IW     = skseq_pkg::CFG_IDX_W;
  localparam int CFG_DW     = skseq_pkg::CFG_DATA_W;
  // generous run limit on the whole run
  localparam longint TIMEOUT_NS = 2_000_000;

  // one input transaction as the sender builds it; opcode stays 3 bits wide so
  // the unused codes can be driven too
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] delta;
    logic [5:0]  slot;
    logic [23:0] dur;
    logic [7:0]  spr;
    logic [7:0]  img;
  } anim_cmd_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  skseq_in_if  in_ch();
  skseq_out_if out_ch();

  sprite_keyframe_sequencer #(
    .MAX_FRAMES(MAX_FRAMES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // ---------------------------------------------------------------------------
  // animation model: own copy of keyframe tables, playback state and registers
  // ---------------------------------------------------------------------------
  logic [23:0] key_dur_mem [MAX_FRAMES];
  logic [7:0]  key_spr_mem [MAX_FRAMES];
  logic [7:0]  key_img_mem [MAX_FRAMES];
  bit          key_loaded  [MAX_FRAMES];
  int          play_pos;
  logic [31:0] play_elapsed;
  bit          play_on;
  bit          play_rev;
  skseq_pkg::wrap_sel_t cur_wrap;
  logic [5:0]  cur_clamp;
  logic [6:0]  cur_count;

  // results predicted at acceptance, oldest first
  skseq_pkg::result_t pending_results[$];
  int                 mismatch_count;

  // receiver stall pattern state
  int rx_mode;
  int rx_span;
  int rx_phase;
  int rx_hold;

  function automatic int clip_len();
    return (cur_count > MAX_FRAMES) ? MAX_FRAMES : int'(cur_count);
  endfunction

  // next state and the result of one accepted transaction
  function automatic skseq_pkg::result_t advance_sequencer(anim_cmd_t c);
    skseq_pkg::result_t r;
    int                 len;
    logic [32:0]        sum;
    r   = '0;
    len = clip_len();
    case (c.op)
      skseq_pkg::OP_TICK: begin
        if (play_on) begin
          if (play_pos >= 0 && play_pos < len) begin
            if (play_elapsed < key_dur_mem[play_pos]) begin
              // still inside the keyframe: accumulate, saturating at 32 bits
              sum          = play_elapsed + c.delta;
              play_elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end else begin
              // keyframe time used up: show it and step on
              r.frame_shown = 1'b1;
              r.out_sprite  = key_spr_mem[play_pos];
              r.out_image   = key_img_mem[play_pos];
              play_elapsed  = play_elapsed - key_dur_mem[play_pos];
              play_pos      = play_pos + (play_rev ? -1 : 1);
            end
          end else begin
            case (cur_wrap)
              skseq_pkg::WRAP_ONCE: begin
                play_on         = 1'b0;
                play_pos        = 0;
                r.stopped_event = 1'b1;
              end
              skseq_pkg::WRAP_LOOP: play_pos = 0;
              skseq_pkg::WRAP_PINGPONG: begin
                if (!play_rev && play_pos == len) begin
                  play_rev = 1'b1;
                  play_pos = play_pos - 1;
                end else if (play_rev && play_pos < 0) begin
                  play_rev        = 1'b0;
                  play_on         = 1'b0;
                  play_pos        = 0;
                  play_elapsed    = '0;
                  r.stopped_event = 1'b1;
                end
              end
              default: play_pos = int'(cur_clamp);
            endcase
          end
        end
      end
      skseq_pkg::OP_PLAY: begin
        play_pos     = 0;
        play_elapsed = '0;
        play_on      = 1'b1;
        play_rev     = 1'b0;
      end
      skseq_pkg::OP_PLAY_REV: begin
        play_pos     = len - 1;
        play_elapsed = '0;
        play_on      = 1'b1;
        play_rev     = 1'b1;
      end
      skseq_pkg::OP_STOP: begin
        play_on         = 1'b0;
        play_pos        = 0;
        r.stopped_event = 1'b1;
      end
      skseq_pkg::OP_LOAD: begin
        key_dur_mem[c.slot] = c.dur;
        key_spr_mem[c.slot] = c.spr;
        key_img_mem[c.slot] = c.img;
        key_loaded[c.slot]  = 1'b1;
      end
      default: ;
    endcase
    r.is_playing = play_on;
    r.position   = 8'(play_pos);
    return r;
  endfunction

  function automatic anim_cmd_t build_cmd(logic [2:0] op, logic [15:0] delta,
                                          logic [5:0] slot, logic [23:0] dur,
                                          logic [7:0] spr, logic [7:0] img);
    anim_cmd_t c;
    c.op    = op;
    c.delta = delta;
    c.slot  = slot;
    c.dur   = dur;
    c.spr   = spr;
    c.img   = img;
    return c;
  endfunction

  // mostly play or reverse play followed by runs of ticks, with loads to keep
  // the clip changing; stops and unused codes are the noise
  function automatic anim_cmd_t random_cmd();
    anim_cmd_t c;
    int        pick;
    pick  = $urandom_range(0, 99);
    c.slot = 6'($urandom);
    c.spr  = 8'($urandom);
    c.img  = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       c.delta = '0;
      1:       c.delta = 16'hFFFF;
      2:       c.delta = 16'($urandom);
      default: c.delta = 16'($urandom_range(0, 2500));
    endcase
    case ($urandom_range(0, 39))
      0:       c.dur = 24'($urandom);
      1, 2:    c.dur = '0;
      default: c.dur = 24'($urandom_range(0, 3000));
    endcase
    if (pick < 68)      c.op = skseq_pkg::OP_TICK;
    else if (pick < 76) c.op = skseq_pkg::OP_PLAY;
    else if (pick < 84) c.op = skseq_pkg::OP_PLAY_REV;
    else if (pick < 88) c.op = skseq_pkg::OP_STOP;
    else if (pick < 97) c.op = skseq_pkg::OP_LOAD;
    else                c.op = 3'($urandom_range(5, 7));
    // a tick must never read a keyframe that was never loaded: load it instead
    if (c.op == skseq_pkg::OP_TICK && play_on && play_pos >= 0 &&
        play_pos < clip_len() && !key_loaded[play_pos]) begin
      c.op   = skseq_pkg::OP_LOAD;
      c.slot = 6'(play_pos);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers: inputs change on the falling edge, handshakes are seen on rising
  // ---------------------------------------------------------------------------
  task automatic send_cmd(anim_cmd_t c);
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.opcode       = c.op;
    in_ch.delta_time   = c.delta;
    in_ch.key_slot     = c.slot;
    in_ch.key_duration = c.dur;
    in_ch.key_sprite   = c.spr;
    in_ch.key_image    = c.img;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transaction accepted at this edge
    pending_results.push_back(advance_sequencer(c));
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
  endtask

  // sender bursts of random length, most of them followed by a random gap
  task automatic send_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_cmd(random_cmd());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  // hold the sender off until every outstanding result has been checked
  task automatic wait_drained();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(skseq_pkg::cfg_index_t idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      skseq_pkg::CFG_WRAP_SEL:    cur_wrap  = skseq_pkg::wrap_sel_t'(val[1:0]);
      skseq_pkg::CFG_CLAMP_FRAME: cur_clamp = val[5:0];
      skseq_pkg::CFG_FRAME_COUNT: cur_count = val;
      default: ;
    endcase
  endtask

  task automatic set_clip(skseq_pkg::wrap_sel_t wrap, logic [5:0] clamp,
                          logic [6:0] count);
    write_reg(skseq_pkg::CFG_WRAP_SEL, CFG_DW'(wrap));
    write_reg(skseq_pkg::CFG_CLAMP_FRAME, CFG_DW'(clamp));
    write_reg(skseq_pkg::CFG_FRAME_COUNT, count);
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    skseq_pkg::result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0b %0h %0h %0b %0b %0d",
                 $time, out_ch.frame_shown, out_ch.out_sprite, out_ch.out_image,
                 out_ch.stopped_event, out_ch.is_playing, out_ch.position);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_shown", 8'(want.frame_shown), 8'(out_ch.frame_shown));
        check_field("out_sprite", want.out_sprite, out_ch.out_sprite);
        check_field("out_image", want.out_image, out_ch.out_image);
        check_field("stopped_event", 8'(want.stopped_event), 8'(out_ch.stopped_event));
        check_field("is_playing", 8'(want.is_playing), 8'(out_ch.is_playing));
        check_field("position", want.position, out_ch.position);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every opcode, stop during play, empty clip
  task automatic test_keyframe_basics();
    int n;
    set_clip(skseq_pkg::WRAP_ONCE, 6'd0, 7'd4);
    send_cmd(build_cmd(skseq_pkg::OP_LOAD, 16'h0000, 6'd0, 24'd0, 8'hFF, 8'h00));
    send_cmd(build_cmd(skseq_pkg::OP_LOAD, 16'hFFFF, 6'd1, 24'd10, 8'h01, 8'h80));
    send_cmd(build_cmd(skseq_pkg::OP_LOAD, 16'h5555, 6'd2, 24'd0, 8'h55, 8'hAA));
    send_cmd(build_cmd(skseq_pkg::OP_LOAD, 16'hAAAA, 6'd3, 24'd65535, 8'hAA, 8'h55));
    send_cmd(build_cmd(skseq_pkg::OP_LOAD, 16'h0000, 6'd63, 24'hFFFFFF, 8'h00, 8'hFF));
    // tick while stopped changes nothing
    send_cmd(build_cmd(skseq_pkg::OP_TICK, 16'hFFFF, 6'd0, 24'd0, 8'h00, 8'h00));
    send_cmd(build_cmd(skseq_pkg::OP_PLAY, 16'h0000, 6'd0, 24'd0, 8'h00, 8'h00));
    // forward through the clip until the position has stepped past its last frame
    for (n = 0; n < 8; n++)
      send_cmd(build_cmd(skseq_pkg::OP_TICK, n[0] ? 16'h0000 : 16'hFFFF, 6'd0, 24'd0,
                         8'h00, 8'h00));
    // stop halts playback and raises the event
    send_cmd(build_cmd(skseq_pkg::OP_STOP, 16'h0000, 6'd0, 24'd0, 8'h00, 8'h00));
    send_cmd(build_cmd(skseq_pkg::OP_PLAY_REV, 16'h0000, 6'd0, 24'd0, 8'h00, 8'h00));
    for (n = 0; n < 5; n++)
      send_cmd(build_cmd(skseq_pkg::OP_TICK, 16'hFFFF, 6'd0, 24'd0, 8'h00, 8'h00));
    // unused opcodes only report status
    send_cmd(build_cmd(3'd7, 16'hFFFF, 6'd63, 24'hFFFFFF, 8'hFF, 8'hFF));
    send_cmd(build_cmd(3'd5, 16'h0000, 6'd0, 24'd0, 8'h00, 8'h00));
    // empty clip: reverse play starts at -1
    wait_drained();
    write_reg(skseq_pkg::CFG_FRAME_COUNT, 7'd0);
    send_cmd(build_cmd(skseq_pkg::OP_PLAY_REV, 16'h0000, 6'd0, 24'd0, 8'h00, 8'h00));
    send_cmd(build_cmd(skseq_pkg::OP_TICK, 16'h0001, 6'd0, 24'd0, 8'h00, 8'h00));
    send_cmd(build_cmd(skseq_pkg::OP_PLAY, 16'h0000, 6'd0, 24'd0, 8'h00, 8'h00));
    send_cmd(build_cmd(skseq_pkg::OP_TICK, 16'h0001, 6'd0, 24'd0, 8'h00, 8'h00));
    wait_drained();
  endtask

  // all four wrap modes over a spread of clip lengths and clamp frames
  task automatic test_wrap_modes();
    int         counts [12] = '{64, 1, 0, 5, 64, 17, 2, 0, 64, 33, 8, 64};
    int         ph;
    logic [5:0] clamp;
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0:       clamp = 6'd0;
        1:       clamp = 6'd63;
        default: clamp = 6'($urandom);
      endcase
      set_clip(skseq_pkg::wrap_sel_t'(ph % 4), clamp, 7'(counts[ph]));
      send_random(100);
      wait_drained();
    end
  endtask

  // traffic with the sender held off mid-stream until every result is back
  task automatic test_drain_hold();
    set_clip(skseq_pkg::WRAP_PINGPONG, 6'd31, 7'd64);
    send_random(100);
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    send_random(100);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // clock, receiver stall pattern, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver switches among always ready, coin toss, periodic and long stalls
  initial begin
    out_ch.ready = 1'b0;
    rx_phase     = 0;
    rx_hold      = 0;
    forever begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(50, 300);
      repeat (rx_span) begin
        @(negedge clk);
        rx_phase++;
        case (rx_mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = 1'($urandom_range(0, 1));
          2: out_ch.ready = (rx_phase % 4) != 3;
          default: begin
            if (rx_hold > 0) begin
              out_ch.ready = 1'b0;
              rx_hold--;
            end else if ($urandom_range(0, 15) == 0) begin
              out_ch.ready = 1'b0;
              rx_hold      = $urandom_range(1, 12);
            end else begin
              out_ch.ready = 1'b1;
            end
          end
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("sprite_keyframe_sequencer_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = '0;
    in_ch.delta_time   = '0;
    in_ch.key_slot     = '0;
    in_ch.key_duration = '0;
    in_ch.key_sprite   = '0;
    in_ch.key_image    = '0;
    mismatch_count     = 0;
    // model state after reset
    for (int i = 0; i < MAX_FRAMES; i++) key_loaded[i] = 1'b0;
    play_pos     = 0;
    play_elapsed = '0;
    play_on      = 1'b0;
    play_rev     = 1'b0;
    cur_wrap     = skseq_pkg::WRAP_ONCE;
    cur_clamp    = '0;
    cur_count    = '0;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_keyframe_basics();
    test_wrap_modes();
    test_drain_hold();

    // all stimulus in: wait for the last results and a few quiet cycles
    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sprite_keyframe_sequencer_tb OK");
    end else begin
      $display("sprite_keyframe_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule
